/* rtl/core/awt_pkg.sv */
`timescale 1ns / 1ps

package awt_pkg;

  localparam int WATCH_ENTRIES_DEF = 16;
  localparam int ADDR_W = 16;
  localparam int FUNC_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CHECK  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // Result handed from the sequencer to the output register
  typedef struct packed {
    logic hit;
    logic status;
  } res_t;

endpackage

/* rtl/core/awt_ram.sv */
`timescale 1ns / 1ps

module awt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/awt_ctrl.sv */
`timescale 1ns / 1ps

module awt_ctrl #(
  parameter int WATCH_ENTRIES = awt_pkg::WATCH_ENTRIES_DEF,
  localparam int IDX_W = (WATCH_ENTRIES > 1) ? $clog2(WATCH_ENTRIES) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [awt_pkg::FUNC_W-1:0] func,
  input  logic [awt_pkg::ADDR_W-1:0] addr,
  output logic                       ram_re,
  output logic [IDX_W-1:0]           ram_raddr,
  input  logic [awt_pkg::ADDR_W-1:0] ram_rdata,
  output logic                       ram_we,
  output logic [IDX_W-1:0]           ram_waddr,
  output logic [awt_pkg::ADDR_W-1:0] ram_wdata,
  output logic                       res_valid,
  input  logic                       res_ready,
  output awt_pkg::res_t              res
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WATCH_ENTRIES - 1);

  awt_pkg::state_t state, state_next;

  logic [awt_pkg::FUNC_W-1:0] func_q;
  logic [awt_pkg::ADDR_W-1:0] addr_q;
  logic                       issuing;
  logic [IDX_W-1:0]           rd_idx;
  logic                       cmp_vld;
  logic [IDX_W-1:0]           cmp_idx;
  logic [WATCH_ENTRIES-1:0]   valid;
  logic                       hit_acc;
  logic                       free_found;
  logic [IDX_W-1:0]           free_idx;

  logic accept;
  logic is_insert;
  logic is_delete;
  logic entry_match;
  logic store;

  assign accept      = in_valid && in_ready;
  assign is_insert   = (func_q == awt_pkg::FUNC_INSERT);
  assign is_delete   = (func_q == awt_pkg::FUNC_DELETE);
  assign entry_match = valid[cmp_idx] && (ram_rdata == addr_q);
  assign store       = is_insert && !hit_acc && free_found;

  always_comb begin
    state_next = state;
    unique case (state)
      awt_pkg::ST_IDLE: begin
        if (in_valid) state_next = awt_pkg::ST_SCAN;
      end
      awt_pkg::ST_SCAN: begin
        if (cmp_vld && (cmp_idx == LAST_IDX)) state_next = awt_pkg::ST_FINISH;
      end
      awt_pkg::ST_FINISH: begin
        if (res_ready) state_next = awt_pkg::ST_IDLE;
      end
      default: state_next = awt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == awt_pkg::ST_IDLE);
    ram_re    = (state == awt_pkg::ST_SCAN) && issuing;
    res_valid = (state == awt_pkg::ST_FINISH);
  end

  assign ram_raddr  = rd_idx;
  assign ram_we     = res_valid && res_ready && store;
  assign ram_waddr  = free_idx;
  assign ram_wdata  = addr_q;
  assign res.hit    = hit_acc;
  assign res.status = is_insert && !hit_acc && !free_found;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= awt_pkg::ST_IDLE;
      issuing <= 1'b0;
      cmp_vld <= 1'b0;
      valid   <= '0;
    end else begin
      state   <= state_next;
      cmp_vld <= ram_re;
      if (accept) begin
        issuing <= 1'b1;
      end else if (ram_re && (rd_idx == LAST_IDX)) begin
        issuing <= 1'b0;
      end
      // delete clears every matching entry as the scan passes it
      if (cmp_vld && entry_match && is_delete) begin
        valid[cmp_idx] <= 1'b0;
      end
      if (ram_we) begin
        valid[free_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= rd_idx;
    if (accept) begin
      func_q     <= func;
      addr_q     <= addr;
      rd_idx     <= '0;
      hit_acc    <= 1'b0;
      free_found <= 1'b0;
    end else begin
      if (ram_re) begin
        rd_idx <= rd_idx + IDX_W'(1);
      end
      if (cmp_vld) begin
        if (entry_match) begin
          hit_acc <= 1'b1;
        end
        // lowest free entry wins
        if (!valid[cmp_idx] && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= cmp_idx;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_store_free: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !valid[free_idx])
    else $error("insert writes an entry that is already valid");

  a_cmp_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmp_vld |-> (state == awt_pkg::ST_SCAN))
    else $error("compare outside of scan");

  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == awt_pkg::ST_SCAN) && issuing)
    else $error("accepted transaction did not start a scan");

  a_finish_quiet: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !issuing && !cmp_vld)
    else $error("result offered while scan still running");

  a_full_only_insert: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status) |-> (is_insert && !hit_acc))
    else $error("full status on a non-insert or on a hit");
`endif

endmodule

/* rtl/core/address_watchpoint_table_unit.sv */
`timescale 1ns / 1ps

// Address watchpoint table: a set of up to WATCH_ENTRIES watched 16-bit
// addresses. Input transaction: func (0 insert, 1 delete, 2 or 3 check) and
// addr, on in_valid/in_ready. Output transaction: hit (address was present
// before the operation) and status (1 = insert dropped, table full), on
// out_valid/out_ready. Exactly one result per input.
// Addresses live in a single-port-read RAM; valid bits are flip-flops. Each
// operation scans the RAM one entry per cycle, and a new input is taken
// only once the result of the last one has left the sequencer for the
// output register.
// One result register sits on the output: the next input is accepted while
// a result waits; if out_ready stays low, the following result holds in the
// sequencer and in_ready stays low until the register drains.
// Reset (rst, synchronous) clears all valid bits at once and empties the
// output register; RAM contents are not cleared and need no clearing pass.
module address_watchpoint_table_unit #(
  parameter int WATCH_ENTRIES = awt_pkg::WATCH_ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [awt_pkg::FUNC_W-1:0] func,
  input  logic [awt_pkg::ADDR_W-1:0] addr,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       hit,
  output logic                       status
);

  localparam int IDX_W = (WATCH_ENTRIES > 1) ? $clog2(WATCH_ENTRIES) : 1;

  logic                       ram_re;
  logic [IDX_W-1:0]           ram_raddr;
  logic [awt_pkg::ADDR_W-1:0] ram_rdata;
  logic                       ram_we;
  logic [IDX_W-1:0]           ram_waddr;
  logic [awt_pkg::ADDR_W-1:0] ram_wdata;
  logic                       res_valid;
  logic                       res_ready;
  awt_pkg::res_t              res;

  awt_ram #(
    .WIDTH (awt_pkg::ADDR_W),
    .DEPTH (WATCH_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  awt_ctrl #(
    .WATCH_ENTRIES (WATCH_ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .addr      (addr),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      hit    <= res.hit;
      status <= res.status;
    end
  end

endmodule
